@@ rtl/vp9_rtp_depacketizer_unit_macros.svh @@
// ----------------------------------------------------------------------------
// VP9 RTP depacketizer assertion macros
// Concurrent checks clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef VP9_RTP_DEPACKETIZER_UNIT_MACROS_SVH
`define VP9_RTP_DEPACKETIZER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define VP9RTP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vp9rtp assertion failed");
// Next-cycle implication
`define VP9RTP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vp9rtp assertion failed");
`else
`define VP9RTP_ASSERT_IMP(lbl, ante, cons)
`define VP9RTP_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

@@ rtl/vp9rtp_pkg.sv @@
// ----------------------------------------------------------------------------
// VP9 RTP depacketizer package
// Shared types, descriptor bit positions and parse phase encoding.
// ----------------------------------------------------------------------------
package vp9rtp_pkg;

    // Payload descriptor flag bit positions (first descriptor byte)
    localparam int unsigned FLAG_I = 7;
    localparam int unsigned FLAG_P = 6;
    localparam int unsigned FLAG_L = 5;
    localparam int unsigned FLAG_F = 4;
    localparam int unsigned FLAG_B = 3;
    localparam int unsigned FLAG_V = 1;
    // Bit 0 of the stored flags holds the SS G bit once the SS byte is seen
    localparam int unsigned FLAG_G = 0;

    // Picture id extension (M) and P_DIFF chain (N)
    localparam int unsigned PID_M  = 7;
    localparam int unsigned PDIFF_N = 0;

    // SS byte fields
    localparam int unsigned SS_Y   = 4;
    localparam int unsigned SS_G   = 3;

    // Number of further P_DIFF bytes allowed after the first one
    localparam logic [1:0] PDIFF_EXTRA = 2'd2;

    // Parse phases, one-hot
    typedef enum logic [12:0] {
        PH_IDLE     = 13'b0000000000001,
        PH_PID      = 13'b0000000000010,
        PH_PIDEXT   = 13'b0000000000100,
        PH_LAYER    = 13'b0000000001000,
        PH_TL0      = 13'b0000000010000,
        PH_PDIFF    = 13'b0000000100000,
        PH_SS       = 13'b0000001000000,
        PH_SIZE     = 13'b0000010000000,
        PH_NG       = 13'b0000100000000,
        PH_GROUP    = 13'b0001000000000,
        PH_GREF     = 13'b0010000000000,
        PH_PAYFIRST = 13'b0100000000000,
        PH_PAYREST  = 13'b1000000000000
    } phase_t;

    // Descriptor part at which a search for the next present part begins
    typedef enum logic [1:0] {
        PART_PID   = 2'd0,
        PART_LAYER = 2'd1,
        PART_PDIFF = 2'd2,
        PART_SS    = 2'd3
    } part_t;

    // One result item
    typedef struct packed {
        logic [7:0]  byte_out;
        logic        frame_start;
        logic        frame_end;
        logic        close_previous;
        logic [31:0] stamp_out;
    } result_t;

    // First present descriptor part at or after the given one
    function automatic phase_t enter_from(input logic [7:0] flags, input part_t part);
        phase_t ph;
        begin
            if (part == PART_PID && flags[FLAG_I])
                ph = PH_PID;
            else if ((part == PART_PID || part == PART_LAYER) && flags[FLAG_L])
                ph = PH_LAYER;
            else if (part != PART_SS && flags[FLAG_P] && flags[FLAG_F])
                ph = PH_PDIFF;
            else if (flags[FLAG_V])
                ph = PH_SS;
            else
                ph = PH_PAYFIRST;
            return ph;
        end
    endfunction

endpackage

@@ rtl/vp9rtp_in_if.sv @@
// ----------------------------------------------------------------------------
// VP9 RTP payload byte channel
// Valid/ready channel carrying one payload byte and its packet info.
// ----------------------------------------------------------------------------
interface vp9rtp_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data;
    logic        first;
    logic        last;
    logic        marker;
    logic [31:0] stamp;

    modport source (output valid, output data, output first, output last,
                    output marker, output stamp, input ready);
    modport sink   (input valid, input data, input first, input last,
                    input marker, input stamp, output ready);
endinterface

@@ rtl/vp9rtp_out_if.sv @@
// ----------------------------------------------------------------------------
// VP9 frame data channel
// Valid/ready channel carrying one frame data byte and its frame markers.
// ----------------------------------------------------------------------------
interface vp9rtp_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  byte_out;
    logic        frame_start;
    logic        frame_end;
    logic        close_previous;
    logic [31:0] stamp_out;

    modport source (output valid, output byte_out, output frame_start,
                    output frame_end, output close_previous, output stamp_out,
                    input ready);
    modport sink   (input valid, input byte_out, input frame_start,
                    input frame_end, input close_previous, input stamp_out,
                    output ready);
endinterface

@@ rtl/vp9rtp_parser.sv @@
// ----------------------------------------------------------------------------
// VP9 payload descriptor parser
// Walks the descriptor one byte per item, drops it, and tags frame data.
// ----------------------------------------------------------------------------
module vp9rtp_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          data,
    input  logic                first,
    input  logic                last,
    input  logic                marker,
    input  logic [31:0]         stamp,
    output logic                res_valid,
    output vp9rtp_pkg::result_t res
);

    vp9rtp_pkg::phase_t phase_reg, phase_next;
    logic [7:0] flags_reg, flags_next;
    logic [5:0] skip_reg, skip_next;
    logic [7:0] groups_reg, groups_next;
    logic [1:0] refs_reg, refs_next;
    logic       open_reg, open_next;

    logic               do_enter;
    vp9rtp_pkg::part_t  enter_part;
    vp9rtp_pkg::phase_t entered;
    logic [5:0]         skip_dec;
    logic [7:0]         groups_dec;
    logic [1:0]         refs_dec;
    logic [1:0]         grp_refs;
    logic               closed;
    logic               still_open;

    assign skip_dec   = skip_reg - 6'd1;
    assign groups_dec = groups_reg - 8'd1;
    assign refs_dec   = refs_reg - 2'd1;
    assign grp_refs   = data[3:2];

    // Next parse state for the accepted item
    always_comb
    begin
        phase_next  = phase_reg;
        flags_next  = flags_reg;
        skip_next   = skip_reg;
        groups_next = groups_reg;
        refs_next   = refs_reg;
        open_next   = open_reg;
        do_enter    = 1'b0;
        enter_part  = vp9rtp_pkg::PART_PID;
        entered     = vp9rtp_pkg::PH_IDLE;
        closed      = 1'b0;
        still_open  = 1'b0;
        res_valid   = 1'b0;
        res         = '0;

        if (accept)
        begin
            if (first)
            begin
                // new descriptor byte; bit 0 reserved for the SS G bit
                flags_next = {data[7:1], 1'b0};
                do_enter   = 1'b1;
                enter_part = vp9rtp_pkg::PART_PID;
            end
            else
            begin
                unique case (phase_reg)
                    vp9rtp_pkg::PH_PID:
                    begin
                        if (data[vp9rtp_pkg::PID_M])
                            phase_next = vp9rtp_pkg::PH_PIDEXT;
                        else
                        begin
                            do_enter   = 1'b1;
                            enter_part = vp9rtp_pkg::PART_LAYER;
                        end
                    end
                    vp9rtp_pkg::PH_PIDEXT:
                    begin
                        do_enter   = 1'b1;
                        enter_part = vp9rtp_pkg::PART_LAYER;
                    end
                    vp9rtp_pkg::PH_LAYER:
                    begin
                        if (flags_reg[vp9rtp_pkg::FLAG_F])
                        begin
                            do_enter   = 1'b1;
                            enter_part = vp9rtp_pkg::PART_PDIFF;
                        end
                        else
                            phase_next = vp9rtp_pkg::PH_TL0;
                    end
                    vp9rtp_pkg::PH_TL0:
                    begin
                        do_enter   = 1'b1;
                        enter_part = vp9rtp_pkg::PART_PDIFF;
                    end
                    vp9rtp_pkg::PH_PDIFF:
                    begin
                        // chain continues while N is set, at most three bytes
                        if (data[vp9rtp_pkg::PDIFF_N] && refs_reg != 2'd0)
                            refs_next = refs_dec;
                        else
                        begin
                            do_enter   = 1'b1;
                            enter_part = vp9rtp_pkg::PART_SS;
                        end
                    end
                    vp9rtp_pkg::PH_SS:
                    begin
                        flags_next = {flags_reg[7:1], data[vp9rtp_pkg::SS_G]};
                        if (data[vp9rtp_pkg::SS_Y])
                        begin
                            skip_next  = {4'({1'b0, data[7:5]} + 4'd1), 2'b00};
                            phase_next = vp9rtp_pkg::PH_SIZE;
                        end
                        else if (data[vp9rtp_pkg::SS_G])
                            phase_next = vp9rtp_pkg::PH_NG;
                        else
                            phase_next = vp9rtp_pkg::PH_PAYFIRST;
                    end
                    vp9rtp_pkg::PH_SIZE:
                    begin
                        skip_next = skip_dec;
                        if (skip_dec == 6'd0)
                            phase_next = flags_reg[vp9rtp_pkg::FLAG_G] ?
                                         vp9rtp_pkg::PH_NG : vp9rtp_pkg::PH_PAYFIRST;
                    end
                    vp9rtp_pkg::PH_NG:
                    begin
                        groups_next = data;
                        phase_next  = (data == 8'd0) ?
                                      vp9rtp_pkg::PH_PAYFIRST : vp9rtp_pkg::PH_GROUP;
                    end
                    vp9rtp_pkg::PH_GROUP:
                    begin
                        groups_next = groups_dec;
                        refs_next   = grp_refs;
                        if (grp_refs != 2'd0)
                            phase_next = vp9rtp_pkg::PH_GREF;
                        else
                            phase_next = (groups_dec == 8'd0) ?
                                         vp9rtp_pkg::PH_PAYFIRST : vp9rtp_pkg::PH_GROUP;
                    end
                    vp9rtp_pkg::PH_GREF:
                    begin
                        refs_next = refs_dec;
                        if (refs_dec == 2'd0)
                            phase_next = (groups_reg == 8'd0) ?
                                         vp9rtp_pkg::PH_PAYFIRST : vp9rtp_pkg::PH_GROUP;
                    end
                    vp9rtp_pkg::PH_PAYFIRST,
                    vp9rtp_pkg::PH_PAYREST:
                    begin
                        // B bit closes an open frame ahead of the first data byte
                        closed = (phase_reg == vp9rtp_pkg::PH_PAYFIRST) &&
                                 flags_reg[vp9rtp_pkg::FLAG_B] && open_reg;
                        still_open = open_reg && !closed;
                        open_next  = !(last && marker);
                        phase_next = vp9rtp_pkg::PH_PAYREST;
                        res_valid  = 1'b1;
                        res.byte_out       = data;
                        res.frame_start    = !still_open;
                        res.frame_end      = last && marker;
                        res.close_previous = closed;
                        res.stamp_out      = stamp;
                    end
                    default:
                    begin
                        // idle: stray byte dropped
                        phase_next = vp9rtp_pkg::PH_IDLE;
                    end
                endcase
            end

            // Jump to the next present descriptor part
            if (do_enter)
            begin
                entered    = vp9rtp_pkg::enter_from(flags_next, enter_part);
                phase_next = entered;
                if (entered == vp9rtp_pkg::PH_PDIFF)
                    refs_next = vp9rtp_pkg::PDIFF_EXTRA;
            end

            // Packet end always returns to idle
            if (last)
                phase_next = vp9rtp_pkg::PH_IDLE;
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= vp9rtp_pkg::PH_IDLE;
            flags_reg  <= '0;
            skip_reg   <= '0;
            groups_reg <= '0;
            refs_reg   <= '0;
            open_reg   <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            flags_reg  <= flags_next;
            skip_reg   <= skip_next;
            groups_reg <= groups_next;
            refs_reg   <= refs_next;
            open_reg   <= open_next;
        end
    end

endmodule

@@ rtl/vp9rtp_out_stage.sv @@
// ----------------------------------------------------------------------------
// VP9 depacketizer output register
// Holds one result item; frees the input side whenever it can be refilled.
// ----------------------------------------------------------------------------
module vp9rtp_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                res_valid,
    input  vp9rtp_pkg::result_t res,
    output logic                load_ok,
    output logic                out_valid,
    input  logic                out_ready,
    output vp9rtp_pkg::result_t out_res
);

    logic                valid_reg, valid_next;
    vp9rtp_pkg::result_t data_reg, data_next;

    // Register is free when empty or being drained this cycle
    assign load_ok = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (load_ok)
        begin
            valid_next = res_valid;
            data_next  = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_res   = data_reg;

endmodule

@@ rtl/vp9_rtp_depacketizer_unit.sv @@
// A frame data item appears on frame_out in the cycle after its byte is accepted.
// Throughput: one byte per cycle unless frame_out stalls; one parse state step per byte.
// Descriptor bytes and packets ending inside their descriptor produce no item.
// Reset (rst_n low, asynchronous) returns the parser to idle with no frame open
// and empties the output register.
// ----------------------------------------------------------------------------
// VP9 RTP depacketizer
// Strips the VP9 payload descriptor and emits frame data bytes with markers.
// ----------------------------------------------------------------------------
`include "vp9_rtp_depacketizer_unit_macros.svh"

module vp9_rtp_depacketizer_unit (
    input  logic         clk,
    input  logic         rst_n,
    vp9rtp_in_if.sink    pkt_in,
    vp9rtp_out_if.source frame_out
);

    logic                accept;
    logic                load_ok;
    logic                res_valid;
    vp9rtp_pkg::result_t res;
    vp9rtp_pkg::result_t out_res;

    assign pkt_in.ready = load_ok;
    assign accept       = pkt_in.valid && load_ok;

    // Descriptor parser
    vp9rtp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data      (pkt_in.data),
        .first     (pkt_in.first),
        .last      (pkt_in.last),
        .marker    (pkt_in.marker),
        .stamp     (pkt_in.stamp),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result register
    vp9rtp_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .load_ok   (load_ok),
        .out_valid (frame_out.valid),
        .out_ready (frame_out.ready),
        .out_res   (out_res)
    );

    assign frame_out.byte_out       = out_res.byte_out;
    assign frame_out.frame_start    = out_res.frame_start;
    assign frame_out.frame_end      = out_res.frame_end;
    assign frame_out.close_previous = out_res.close_previous;
    assign frame_out.stamp_out      = out_res.stamp_out;

    // A stalled result blocks the input
    `VP9RTP_ASSERT_IMP(a_stall_blocks_input, frame_out.valid && !frame_out.ready, !pkt_in.ready)
    // A descriptor start byte never yields an item
    `VP9RTP_ASSERT_NXT(a_first_no_item, pkt_in.valid && pkt_in.ready && pkt_in.first, !frame_out.valid)
    // Closing the previous frame always opens a new one
    `VP9RTP_ASSERT_IMP(a_close_starts_frame, frame_out.valid && frame_out.close_previous, frame_out.frame_start)

endmodule
